[hdl/pidl_pkg.sv]
package pidl_pkg;

    // fixed point one in Q16.16 and Q0.16
    localparam logic [16:0] Q_ONE = 17'd65536;

    // register reset values
    localparam logic [30:0] GAIN_P_RST = 31'd13107200;
    localparam logic [30:0] GAIN_I_RST = 31'd26214400;
    localparam logic [30:0] GAIN_D_RST = 31'd52429;
    localparam logic [30:0] BOUND_RST  = 31'd65536;

    // output bounds
    localparam logic signed [31:0] OUT_MIN_DEF = 32'sh8000_0000;
    localparam logic signed [31:0] OUT_MAX_DEF = 32'sh7FFF_FFFF;

    // divider: 33-bit difference shifted by 16 gives a 49-bit magnitude
    localparam int NUM_W     = 49;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam int ADDR_W = 5;

    // register map, index = paddr / 4
    typedef enum logic [2:0] {
        REG_GAIN_P   = 3'd0,
        REG_GAIN_I   = 3'd1,
        REG_GAIN_D   = 3'd2,
        REG_BOUND    = 3'd3,
        REG_LEAK     = 3'd4,
        REG_DEADBAND = 3'd5,
        REG_SLOW_TH  = 3'd6,
        REG_SLOW_W   = 3'd7
    } reg_idx_t;

    // saturate a signed 64-bit value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

[hdl/pidl_mul.sv]
// Shared signed 32x32 multiplier, product registered
module pidl_mul (
    input  logic               aclk,
    input  logic signed [31:0] op_a,
    input  logic signed [31:0] op_b,
    output logic signed [63:0] prod
);

    logic signed [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

[hdl/pidl_div.sv]
// Restoring divider, one quotient bit per cycle, truncates toward zero
module pidl_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [pidl_pkg::NUM_W-1:0] num,
    input  logic [30:0]                      den,
    output logic                             busy,
    output logic signed [pidl_pkg::NUM_W:0]  quot
);

    localparam int NW = pidl_pkg::NUM_W;
    localparam int CW = pidl_pkg::CNT_W;

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic          neg_reg;
    logic [NW-1:0] q_reg;
    logic [30:0]   rem_reg;
    logic [30:0]   den_reg;

    logic [31:0]   trial;
    logic          ge;
    logic [31:0]   diff;
    logic [30:0]   rem_next;
    logic [NW-1:0] num_mag;

    assign num_mag  = num[NW-1] ? NW'(-num) : NW'(num);
    assign trial    = {rem_reg, q_reg[NW-1]};
    assign ge       = trial >= {1'b0, den_reg};
    assign diff     = trial - {1'b0, den_reg};
    assign rem_next = ge ? diff[30:0] : trial[30:0];

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(pidl_pkg::DIV_STEPS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= num[NW-1];
            q_reg   <= num_mag;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[NW-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quot = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

endmodule

[hdl/pid_controller_leaky_integral_top.sv]
// Channel   Direction  Content
// s_        in         tdata: target[31:0], measured[63:32], step_time[94:64]
// m_        out        tdata: drive, error_now, p_term, i_term, d_term, drive_clamped,
//                      zero_step (lowest first)
// apb       in/out     eight 32-bit registers at byte address 4*index
//
// Items are taken one at a time; the bit-serial derivative divider (49 steps) sets
// the pace, and the first six of the seven multiplies on the shared unit run beside
// it. With step_time zero the divider is skipped and an item finishes sooner.
// s_tready is high only in idle; a finished result sits in the output register,
// so the next item is taken while it waits, and is held back only at the final
// step if the previous result is still not taken.
// aresetn (synchronous) clears the integral, last error and registers to defaults.
module pid_controller_leaky_integral_top #(
    parameter logic signed [31:0] OUT_MIN = pidl_pkg::OUT_MIN_DEF,
    parameter logic signed [31:0] OUT_MAX = pidl_pkg::OUT_MAX_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input items
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [95:0]                 s_tdata,  // target, measured, step_time
    // results
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [167:0]                m_tdata,  // drive, error_now, p, i, d, clamp, zero
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pidl_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_ERR   = 14'b00000000000010,
        ST_LEAK  = 14'b00000000000100,
        ST_ED    = 14'b00000000001000,
        ST_GH    = 14'b00000000010000,
        ST_GL    = 14'b00000000100000,
        ST_ACC   = 14'b00000001000000,
        ST_CLAMP = 14'b00000010000000,
        ST_P     = 14'b00000100000000,
        ST_I     = 14'b00001000000000,
        ST_DWAIT = 14'b00010000000000,
        ST_D     = 14'b00100000000000,
        ST_DT    = 14'b01000000000000,
        ST_SUM   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [30:0] gain_p_reg, gain_i_reg, gain_d_reg, bound_reg;
    logic [16:0] leak_reg, slow_w_reg;
    logic [30:0] deadband_reg, slow_th_reg;

    // state kept between items
    logic signed [31:0] acc_reg, last_reg;

    // item working registers
    logic signed [31:0] tgt_reg, meas_reg;
    logic [30:0]        dt_reg;
    logic signed [31:0] err_reg;
    logic               integ_reg;
    logic [16:0]        w_reg;
    logic signed [33:0] kept_reg;
    logic [15:0]        edl_reg;
    logic signed [49:0] gh_reg;
    logic signed [31:0] tmp_reg;
    logic signed [31:0] p_reg, i_reg, d_reg, deriv_reg;

    // output register
    logic               m_valid_reg;
    logic [167:0]       m_data_reg;

    // shared multiplier
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;

    // divider
    logic               div_start, div_busy;
    logic signed [pidl_pkg::NUM_W-1:0] div_num;
    logic signed [pidl_pkg::NUM_W:0]   div_quot;

    logic               cfg_wr;
    logic signed [32:0] err_wide;
    logic [31:0]        aerr;
    logic [16:0]        leak_c, sw_c, keep_f;
    logic signed [32:0] ediff;
    logic signed [51:0] acc_sum;
    logic signed [32:0] bound_pos, bound_neg;
    logic signed [31:0] acc_src;
    logic signed [33:0] pid_sum;
    logic               out_free;

    pidl_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    pidl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (dt_reg),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    // APB register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg   <= pidl_pkg::GAIN_P_RST;
            gain_i_reg   <= pidl_pkg::GAIN_I_RST;
            gain_d_reg   <= pidl_pkg::GAIN_D_RST;
            bound_reg    <= pidl_pkg::BOUND_RST;
            leak_reg     <= '0;
            deadband_reg <= '0;
            slow_th_reg  <= '0;
            slow_w_reg   <= '0;
        end else if (cfg_wr) begin
            case (pidl_pkg::reg_idx_t'(paddr[4:2]))
                pidl_pkg::REG_GAIN_P:   gain_p_reg   <= pwdata[30:0];
                pidl_pkg::REG_GAIN_I:   gain_i_reg   <= pwdata[30:0];
                pidl_pkg::REG_GAIN_D:   gain_d_reg   <= pwdata[30:0];
                pidl_pkg::REG_BOUND:    bound_reg    <= pwdata[30:0];
                pidl_pkg::REG_LEAK:     leak_reg     <= pwdata[16:0];
                pidl_pkg::REG_DEADBAND: deadband_reg <= pwdata[30:0];
                pidl_pkg::REG_SLOW_TH:  slow_th_reg  <= pwdata[30:0];
                pidl_pkg::REG_SLOW_W:   slow_w_reg   <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (pidl_pkg::reg_idx_t'(paddr[4:2]))
            pidl_pkg::REG_GAIN_P:   prdata = {1'b0, gain_p_reg};
            pidl_pkg::REG_GAIN_I:   prdata = {1'b0, gain_i_reg};
            pidl_pkg::REG_GAIN_D:   prdata = {1'b0, gain_d_reg};
            pidl_pkg::REG_BOUND:    prdata = {1'b0, bound_reg};
            pidl_pkg::REG_LEAK:     prdata = {15'b0, leak_reg};
            pidl_pkg::REG_DEADBAND: prdata = {1'b0, deadband_reg};
            pidl_pkg::REG_SLOW_TH:  prdata = {1'b0, slow_th_reg};
            pidl_pkg::REG_SLOW_W:   prdata = {15'b0, slow_w_reg};
            default:                prdata = '0;
        endcase
    end

    // small datapath pieces
    assign err_wide = $signed({tgt_reg[31], tgt_reg}) - $signed({meas_reg[31], meas_reg});
    assign aerr     = err_reg[31] ? 32'(-err_reg) : 32'(err_reg);
    assign leak_c   = (leak_reg > pidl_pkg::Q_ONE) ? pidl_pkg::Q_ONE : leak_reg;
    assign sw_c     = (slow_w_reg > pidl_pkg::Q_ONE) ? pidl_pkg::Q_ONE : slow_w_reg;
    assign keep_f   = pidl_pkg::Q_ONE - leak_c;
    assign ediff    = $signed({err_reg[31], err_reg}) - $signed({last_reg[31], last_reg});
    assign div_num  = $signed({ediff, 16'b0});
    assign div_start = (state_reg == ST_LEAK) && (dt_reg != '0);

    // kept + w*edh + floor(w*edl / 2^16)
    assign acc_sum = 52'(kept_reg) + 52'(gh_reg) + 52'(prod >>> 16);
    assign acc_src   = integ_reg ? tmp_reg : acc_reg;
    assign bound_pos = $signed({2'b0, bound_reg});
    assign bound_neg = -bound_pos;
    assign pid_sum   = 34'(p_reg) + 34'(i_reg) + 34'(d_reg);
    assign out_free  = !m_valid_reg || m_tready;

    // multiplier operand select; integral operands stay on while the divider runs
    always_comb begin
        case (state_reg)
            ST_LEAK: begin
                mul_a = $signed({15'b0, keep_f});
                mul_b = acc_reg;
            end
            ST_ED: begin
                mul_a = err_reg;
                mul_b = $signed({1'b0, dt_reg});
            end
            ST_GH: begin
                mul_a = $signed({15'b0, w_reg});
                mul_b = prod[63:32];
            end
            ST_GL: begin
                mul_a = $signed({15'b0, w_reg});
                mul_b = $signed({16'b0, edl_reg});
            end
            ST_P: begin
                mul_a = $signed({1'b0, gain_p_reg});
                mul_b = err_reg;
            end
            ST_I, ST_DWAIT: begin
                mul_a = $signed({1'b0, gain_i_reg});
                mul_b = acc_reg;
            end
            ST_D: begin
                mul_a = $signed({1'b0, gain_d_reg});
                mul_b = deriv_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_ERR;
            ST_ERR:   state_next = ST_LEAK;
            ST_LEAK:  state_next = ST_ED;
            ST_ED:    state_next = ST_GH;
            ST_GH:    state_next = ST_GL;
            ST_GL:    state_next = ST_ACC;
            ST_ACC:   state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_P;
            ST_P:     state_next = ST_I;
            ST_I:     state_next = ST_DWAIT;
            ST_DWAIT: if (!div_busy) state_next = ST_D;
            ST_D:     state_next = ST_DT;
            ST_DT:    state_next = ST_SUM;
            ST_SUM:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            last_reg <= '0;
        end else if (state_reg == ST_CLAMP) begin
            if (33'(acc_src) > bound_pos) begin
                acc_reg <= bound_pos[31:0];
            end else if (33'(acc_src) < bound_neg) begin
                acc_reg <= bound_neg[31:0];
            end else begin
                acc_reg <= acc_src;
            end
            last_reg <= err_reg;
        end
    end

    // item datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                tgt_reg  <= s_tdata[31:0];
                meas_reg <= s_tdata[63:32];
                dt_reg   <= s_tdata[94:64];
            end
            ST_ERR: err_reg <= pidl_pkg::sat32(64'(err_wide));
            ST_LEAK: begin
                integ_reg <= aerr > {1'b0, deadband_reg};
                w_reg     <= (aerr > {1'b0, slow_th_reg}) ? pidl_pkg::Q_ONE : sw_c;
            end
            ST_ED:  kept_reg <= 34'(prod >>> 16);
            ST_GH:  edl_reg <= prod[31:16];
            ST_GL:  gh_reg <= 50'(prod);
            ST_ACC: tmp_reg <= pidl_pkg::sat32(64'(acc_sum));
            ST_I:   p_reg <= pidl_pkg::sat32(prod >>> 16);
            ST_DWAIT: begin
                // i product is ready on the first wait cycle and stays there
                i_reg <= pidl_pkg::sat32(prod >>> 16);
                if (state_next == ST_D) begin
                    deriv_reg <= (dt_reg == '0) ? 32'sd0 : pidl_pkg::sat32(64'(div_quot));
                end
            end
            ST_DT:  d_reg <= pidl_pkg::sat32(prod >>> 16);
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_SUM && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SUM && out_free) begin
            m_data_reg[31:0]    <= (pid_sum > 34'(OUT_MAX)) ? OUT_MAX :
                                   (pid_sum < 34'(OUT_MIN)) ? OUT_MIN : pid_sum[31:0];
            m_data_reg[63:32]   <= err_reg;
            m_data_reg[95:64]   <= p_reg;
            m_data_reg[127:96]  <= i_reg;
            m_data_reg[159:128] <= d_reg;
            m_data_reg[160]     <= (pid_sum > 34'(OUT_MAX)) || (pid_sum < 34'(OUT_MIN));
            m_data_reg[161]     <= (dt_reg == '0);
            m_data_reg[167:162] <= '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[dv/tb_pid_controller_leaky_integral_top.sv]
module tb_pid_controller_leaky_integral_top;

    typedef struct packed {
        logic [30:0] step_time;
        logic signed [31:0] measured;
        logic signed [31:0] target;
    } ctl_in_t;

    typedef struct packed {
        logic        zero_step;
        logic        drive_clamped;
        logic signed [31:0] d_term;
        logic signed [31:0] i_term;
        logic signed [31:0] p_term;
        logic signed [31:0] error_now;
        logic signed [31:0] drive;
    } ctl_out_t;

    localparam int LIMIT_CYCLES = 400000;
    localparam logic [63:0] ONE64 = 64'd65536;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [95:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [167:0] m_tdata;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [pidl_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    pid_controller_leaky_integral_top dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow of the controller state and registers
    logic [30:0] kp, ki, kd, ibound, dband, slow_th;
    logic [16:0] leak, slow_w;
    logic signed [63:0] integ, prev_err;

    ctl_in_t  pending_items[$];
    ctl_out_t expected_results[$];
    int  failures = 0;
    bit  quiet_phase = 0;   // no idling on either side
    int  phase_no = -1;     // random phase now running
    int  hold_off = 0;      // receiver long stall, cycles remaining
    bit  hold_done = 0;
    bit  in_taken = 0;      // an input item was accepted at the last rising edge
    longint cycle = 0;

    function automatic logic signed [63:0] clip32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // arithmetic shift right gives floor division by 65536
    function automatic logic signed [63:0] fl16(input logic signed [63:0] x);
        return x >>> 16;
    endfunction

    function automatic ctl_out_t pid_predict(input ctl_in_t it);
        ctl_out_t r;
        logic signed [63:0] e, ae, dt, lk, sw, w, kept, ed, gn, der, p, i, d, s, b;
        e  = clip32(64'(it.target) - 64'(it.measured));
        ae = e < 0 ? -e : e;
        dt = 64'(it.step_time);
        b  = 64'(ibound);
        der = 0;
        if (ae > 64'(dband)) begin
            lk = (64'(leak) > ONE64) ? ONE64 : 64'(leak);
            sw = (64'(slow_w) > ONE64) ? ONE64 : 64'(slow_w);
            w  = (ae > 64'(slow_th)) ? 64'sd65536 : sw;
            kept = fl16((64'sd65536 - lk) * integ);
            ed   = fl16(e * dt);
            gn   = fl16(w * ed);
            integ = clip32(kept + gn);
        end
        if (integ > b) integ = b;
        if (integ < -b) integ = -b;
        if (dt != 0) der = clip32(((e - prev_err) * 64'sd65536) / dt);
        p = clip32(fl16(64'(kp) * e));
        i = clip32(fl16(64'(ki) * integ));
        d = clip32(fl16(64'(kd) * der));
        s = p + i + d;
        r.drive_clamped = (s > 64'sd2147483647) || (s < -64'sd2147483648);
        r.drive = 32'(clip32(s));
        r.error_now = 32'(e);
        r.p_term = 32'(p);
        r.i_term = 32'(i);
        r.d_term = 32'(d);
        r.zero_step = (dt == 0);
        prev_err = e;
        return r;
    endfunction

    // input driver: an offered item stays until accepted
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !in_taken) begin
                s_tvalid <= 1'b1;
            end else if (pending_items.size() > 0 &&
                         (quiet_phase || $urandom_range(99) >= 25)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, pending_items[0]};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready, with one long hold-off in phase five
    always @(negedge aclk) begin
        if (aresetn) begin
            if (phase_no == 5 && !hold_done) begin
                hold_done <= 1'b1;
                hold_off  <= 400;
                m_tready  <= 1'b0;
            end else if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet_phase || ($urandom_range(99) >= 25);
            end
        end
    end

    // handshake-accurate predictor on accept, checker on result
    always @(posedge aclk) begin
        ctl_out_t got, exp_r;
        cycle <= cycle + 1;
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            expected_results.push_back(pid_predict(ctl_in_t'(s_tdata[94:0])));
            void'(pending_items.pop_front());
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = ctl_out_t'(m_tdata[161:0]);
            if (expected_results.size() == 0) begin
                $display("%0t: result with none expected, actual %h", $time, got);
                failures++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r) begin
                    $display("%0t: mismatch expected drive %0d err %0d p %0d i %0d d %0d c %b z %b",
                        $time, exp_r.drive, exp_r.error_now, exp_r.p_term, exp_r.i_term,
                        exp_r.d_term, exp_r.drive_clamped, exp_r.zero_step);
                    $display("%0t:          actual   drive %0d err %0d p %0d i %0d d %0d c %b z %b",
                        $time, got.drive, got.error_now, got.p_term, got.i_term,
                        got.d_term, got.drive_clamped, got.zero_step);
                    failures++;
                end
            end
        end
        if (cycle > LIMIT_CYCLES) begin
            $display("** pid_controller_leaky_integral_top: FAILED **");
            $finish;
        end
    end

    task automatic reg_write(input pidl_pkg::reg_idx_t idx, input logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            pidl_pkg::REG_GAIN_P:   kp = val[30:0];
            pidl_pkg::REG_GAIN_I:   ki = val[30:0];
            pidl_pkg::REG_GAIN_D:   kd = val[30:0];
            pidl_pkg::REG_BOUND:    ibound = val[30:0];
            pidl_pkg::REG_LEAK:     leak = val[16:0];
            pidl_pkg::REG_DEADBAND: dband = val[30:0];
            pidl_pkg::REG_SLOW_TH:  slow_th = val[30:0];
            pidl_pkg::REG_SLOW_W:   slow_w = val[16:0];
            default: ;
        endcase
    endtask

    task automatic add_item(input logic [31:0] t, input logic [31:0] m, input logic [30:0] dt);
        ctl_in_t it;
        it.target = t;
        it.measured = m;
        it.step_time = dt;
        pending_items.push_back(it);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    // random item: mostly modest values, sometimes full range
    task automatic add_random_item();
        logic [31:0] t, m;
        logic [30:0] dt;
        if ($urandom_range(3) == 0) begin
            t = $urandom; m = $urandom; dt = 31'($urandom);
        end else begin
            t = 32'($signed($urandom_range(600000)) - 300000);
            m = 32'($signed($urandom_range(600000)) - 300000);
            case ($urandom_range(4))
                0: dt = '0;
                1: dt = 31'($urandom);
                default: dt = 31'($urandom_range(200000));
            endcase
        end
        add_item(t, m, dt);
    endtask

    // one register setting per phase, extremes included
    task automatic set_phase(input int ph);
        case (ph)
            0: begin
                reg_write(pidl_pkg::REG_GAIN_P, 32'h7FFF_FFFF);
                reg_write(pidl_pkg::REG_GAIN_I, 32'h7FFF_FFFF);
                reg_write(pidl_pkg::REG_GAIN_D, 32'h7FFF_FFFF);
                reg_write(pidl_pkg::REG_BOUND, 32'h7FFF_FFFF);
                reg_write(pidl_pkg::REG_LEAK, 32'd65536);
                reg_write(pidl_pkg::REG_DEADBAND, 32'd0);
                reg_write(pidl_pkg::REG_SLOW_TH, 32'h7FFF_FFFF);
                reg_write(pidl_pkg::REG_SLOW_W, 32'h1FFFF);
            end
            1: begin
                reg_write(pidl_pkg::REG_GAIN_P, 32'd0);
                reg_write(pidl_pkg::REG_GAIN_I, 32'd0);
                reg_write(pidl_pkg::REG_GAIN_D, 32'd0);
                reg_write(pidl_pkg::REG_BOUND, 32'd0);
                reg_write(pidl_pkg::REG_LEAK, 32'h1FFFF);
                reg_write(pidl_pkg::REG_DEADBAND, 32'h7FFF_FFFF);
                reg_write(pidl_pkg::REG_SLOW_TH, 32'd0);
                reg_write(pidl_pkg::REG_SLOW_W, 32'd0);
            end
            default: begin
                reg_write(pidl_pkg::REG_GAIN_P, $urandom_range(200000));
                reg_write(pidl_pkg::REG_GAIN_I, $urandom);
                reg_write(pidl_pkg::REG_GAIN_D, $urandom_range(100000));
                reg_write(pidl_pkg::REG_BOUND,
                          $urandom_range(3) == 0 ? $urandom : $urandom_range(5000000));
                reg_write(pidl_pkg::REG_LEAK, $urandom_range(70000));
                reg_write(pidl_pkg::REG_DEADBAND, $urandom_range(20000));
                reg_write(pidl_pkg::REG_SLOW_TH, $urandom_range(150000));
                reg_write(pidl_pkg::REG_SLOW_W, $urandom_range(65536));
            end
        endcase
    endtask

    initial begin
        kp = pidl_pkg::GAIN_P_RST; ki = pidl_pkg::GAIN_I_RST;
        kd = pidl_pkg::GAIN_D_RST; ibound = pidl_pkg::BOUND_RST;
        leak = 0; dband = 0; slow_th = 0; slow_w = 0;
        integ = 0; prev_err = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: defaults, field extremes, zero step, error overflow
        add_item(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
        add_item(32'h8000_0000, 32'h7FFF_FFFF, 31'd0);
        add_item(32'd65536, 32'd0, 31'd65536);
        add_item(32'd0, 32'd0, 31'd0);
        add_item(32'hFFFF_FFFF, 32'd1, 31'd1);
        add_item(32'd12345, 32'hFFFF_0000, 31'd655);
        drain();
        set_phase(0);
        add_item(32'h7FFF_FFFF, 32'd0, 31'h7FFF_FFFF);
        add_item(32'h8000_0000, 32'd0, 31'h7FFF_FFFF);
        add_item(32'd100, 32'd50, 31'd0);
        add_item(32'h0001_0000, 32'h8000_0000, 31'd1);
        drain();
        set_phase(1);
        add_item(32'h7FFF_FFFF, 32'h8000_0000, 31'd3);
        add_item(32'd5, 32'd7, 31'd0);
        drain();

        // random phases; one with no idling, one with a long receiver stall
        for (int ph = 0; ph < 8; ph++) begin
            set_phase(ph < 2 ? ph : 2);
            quiet_phase = (ph == 4);
            phase_no = ph;
            repeat (80) add_random_item();
            drain();
        end
        quiet_phase = 0;

        if (failures == 0) begin
            $display("** pid_controller_leaky_integral_top: PASSED **");
        end else begin
            $display("** pid_controller_leaky_integral_top: FAILED **");
        end
        $finish;
    end

endmodule
